>>> hdl/hhp_pkg.sv
package hhp_pkg;

   // Width of the running count; the count saturates at all ones.
   localparam int COUNT_WIDTH     = 31;
   // Width of the count field on the result channel.
   localparam int OUT_COUNT_WIDTH = 31;
   // Room for acc * 10 + 9 without wrapping.
   localparam int PROD_WIDTH      = COUNT_WIDTH + 4;

   typedef logic [1:0]                 kind_type;
   typedef logic [7:0]                 byte_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [OUT_COUNT_WIDTH-1:0] out_count_type;
   typedef logic [3:0]                 digit_type;

   localparam kind_type KIND_ENTRY = 2'd0;
   localparam kind_type KIND_END   = 2'd1;
   localparam kind_type KIND_ERROR = 2'd2;

   localparam byte_type CHAR_ZERO    = 8'h30;
   localparam byte_type CHAR_NINE    = 8'h39;
   localparam byte_type CHAR_NEWLINE = 8'h0A;

   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

>>> hdl/histogram_header_parser_core.sv
// Symbol-frequency header parser.
//
// Input channel (req_*): one raw header byte per item. Each entry is a symbol
// byte, decimal digits, then a newline; other bytes inside an entry are
// skipped. Result channel (rsp_*): kind, symbol and count of a finished
// entry. Kind ENTRY carries a nonzero count, END marks the zero-count stop
// entry, ERROR flags a nonzero symbol not above the previous one. After END
// or ERROR all bytes are swallowed until reset.
//
// Latency: the result for a newline byte is on rsp_* the cycle after that
// byte is taken. Throughput: one byte per cycle while req_stall is low;
// the parse state updates in a single pass through the decimal shift-add
// and the ordering compare. One result register sits on the output.
// req_stall is raised only while that register holds an item and the
// receiver stalls it; a held result stays unchanged until taken.
//
// Reset (synchronous, active high) clears the parse state and empties the
// result register; the next byte is treated as a symbol byte.
module histogram_header_parser_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hhp_pkg::byte_type        req_byte_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hhp_pkg::kind_type        rsp_kind,
   output hhp_pkg::byte_type        rsp_symbol,
   output hhp_pkg::out_count_type   rsp_count
);

   // parse state
   logic                   in_digits_ff, in_digits_in;
   hhp_pkg::byte_type      cur_sym_ff, cur_sym_in;
   hhp_pkg::byte_type      prev_sym_ff, prev_sym_in;
   hhp_pkg::count_type     acc_ff, acc_in;
   logic                   finished_ff, finished_in;
   logic                   failed_ff, failed_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   hhp_pkg::kind_type      rsp_kind_ff, rsp_kind_in;
   hhp_pkg::byte_type      rsp_symbol_ff, rsp_symbol_in;
   hhp_pkg::out_count_type rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   emit;
   logic                   is_digit;
   hhp_pkg::byte_type      digit_off;
   hhp_pkg::count_type     acc_step;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_digit  = req_byte_in inside {[hhp_pkg::CHAR_ZERO:hhp_pkg::CHAR_NINE]};
   assign digit_off = req_byte_in - hhp_pkg::CHAR_ZERO;

   hhp_digit_acc u_digit_acc (
      .acc      (acc_ff),
      .digit    (digit_off[3:0]),
      .acc_next (acc_step)
   );

   always_comb begin
      in_digits_in  = in_digits_ff;
      cur_sym_in    = cur_sym_ff;
      prev_sym_in   = prev_sym_ff;
      acc_in        = acc_ff;
      finished_in   = finished_ff;
      failed_in     = failed_ff;
      emit          = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_count_in  = rsp_count_ff;

      if (accept && !finished_ff && !failed_ff) begin
         if (!in_digits_ff) begin
            // any byte here is the symbol, newline and digits included
            cur_sym_in   = req_byte_in;
            acc_in       = '0;
            in_digits_in = 1'b1;
         end else if (is_digit) begin
            acc_in = acc_step;
         end else if (req_byte_in == hhp_pkg::CHAR_NEWLINE) begin
            in_digits_in  = 1'b0;
            emit          = 1'b1;
            rsp_symbol_in = cur_sym_ff;
            rsp_count_in  = hhp_pkg::OUT_COUNT_WIDTH'(acc_ff);
            if (acc_ff == '0) begin
               // stop mark, no ordering check
               finished_in = 1'b1;
               rsp_kind_in = hhp_pkg::KIND_END;
            end else if (cur_sym_ff != '0 && cur_sym_ff <= prev_sym_ff) begin
               failed_in   = 1'b1;
               rsp_kind_in = hhp_pkg::KIND_ERROR;
            end else begin
               prev_sym_in = cur_sym_ff;
               rsp_kind_in = hhp_pkg::KIND_ENTRY;
            end
         end
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_digits_ff <= 1'b0;
         cur_sym_ff   <= '0;
         prev_sym_ff  <= '0;
         acc_ff       <= '0;
         finished_ff  <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_digits_ff <= in_digits_in;
         cur_sym_ff   <= cur_sym_in;
         prev_sym_ff  <= prev_sym_in;
         acc_ff       <= acc_in;
         finished_ff  <= finished_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_count  = rsp_count_ff;

   // Once terminated, a drained result register stays empty.
   a_quiet_after_done: assert property (@(posedge clock) disable iff (reset)
      (finished_ff || failed_ff) && rsp_valid_ff && !rsp_stall |=> !rsp_valid_ff)
      else $error("result produced after stop mark or error");

   // A stop-mark result always coincides with the finished flag being set.
   a_end_sets_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == hhp_pkg::KIND_END |-> finished_ff)
      else $error("stop mark reported without finished state");

   // A regular entry never carries a zero count.
   a_entry_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == hhp_pkg::KIND_ENTRY |-> rsp_count_ff != '0)
      else $error("entry result with zero count");

endmodule

>>> hdl/hhp_digit_acc.sv
// Decimal shift-add: acc * 10 + digit, clamped at the count maximum.
module hhp_digit_acc (
   input  hhp_pkg::count_type acc,
   input  hhp_pkg::digit_type digit,
   output hhp_pkg::count_type acc_next
);

   logic [hhp_pkg::PROD_WIDTH-1:0] acc_ext;
   logic [hhp_pkg::PROD_WIDTH-1:0] prod;
   logic [hhp_pkg::PROD_WIDTH-1:0] max_ext;

   assign acc_ext = hhp_pkg::PROD_WIDTH'(acc);
   assign max_ext = hhp_pkg::PROD_WIDTH'(hhp_pkg::COUNT_MAX);
   // x*10 = x*8 + x*2
   assign prod    = (acc_ext << 3) + (acc_ext << 1) + hhp_pkg::PROD_WIDTH'(digit);

   always_comb begin
      if (prod > max_ext) begin
         acc_next = hhp_pkg::COUNT_MAX;
      end else begin
         acc_next = hhp_pkg::COUNT_WIDTH'(prod);
      end
   end

endmodule
